// File: src/hssd_pkg.sv
// Shared types, constants and lookup functions for the Hall sensor decoder.
// Used by every module of the block; depends on nothing.
package hssd_pkg;

	localparam int NUMER_BITS        = 24;
	localparam int INTERVAL_BITS_DEF = 16;
	localparam int SECTOR_BITS       = 3;
	localparam int ROT_BITS          = 2;
	localparam int ANGLE_BITS        = 9;
	localparam int TOTAL_BITS        = 32;
	localparam int QUEUE_DEPTH       = 2;
	localparam int ADDR_BITS         = 3;
	localparam int DATA_BITS         = 32;

	localparam logic [NUMER_BITS-1:0] RPM_NUMER_RESET = 24'd5000000;

	// register index, taken from paddr above the byte offset
	localparam logic REG_RPM_NUMERATOR = 1'b0;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_INIT = 1'b1;

	localparam logic signed [ROT_BITS-1:0] ROT_NONE = 2'sb00;
	localparam logic signed [ROT_BITS-1:0] ROT_FWD  = 2'sb01;
	localparam logic signed [ROT_BITS-1:0] ROT_REV  = 2'sb11;

	localparam logic [SECTOR_BITS-1:0] SECTOR_NONE = 3'd0;

	typedef enum logic [1:0] {
		KIND_EDGE,
		KIND_INIT,
		KIND_REJECT
	} item_kind_t;

	typedef struct packed {
		item_kind_t             kind;
		logic [SECTOR_BITS-1:0] sector;
	} item_cls_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_COMMIT
	} back_state_t;

	function automatic logic [SECTOR_BITS-1:0] sector_of_raw(input logic [2:0] raw);
		logic [SECTOR_BITS-1:0] s;
		unique case (raw)
			3'd1:    s = 3'd4;
			3'd2:    s = 3'd1;
			3'd3:    s = 3'd5;
			3'd4:    s = 3'd2;
			3'd5:    s = 3'd6;
			3'd6:    s = 3'd3;
			default: s = SECTOR_NONE;
		endcase
		return s;
	endfunction

	// forward sequence 1-5-4-6-2-3-1
	function automatic logic [SECTOR_BITS-1:0] fwd_after(input logic [SECTOR_BITS-1:0] s);
		logic [SECTOR_BITS-1:0] n;
		unique case (s)
			3'd1:    n = 3'd5;
			3'd2:    n = 3'd3;
			3'd3:    n = 3'd1;
			3'd4:    n = 3'd6;
			3'd5:    n = 3'd4;
			3'd6:    n = 3'd2;
			default: n = SECTOR_NONE;
		endcase
		return n;
	endfunction

	function automatic logic [ANGLE_BITS-1:0] deg_of_sector(input logic [SECTOR_BITS-1:0] s);
		logic [ANGLE_BITS-1:0] d;
		unique case (s)
			3'd2:    d = 9'd240;
			3'd3:    d = 9'd300;
			3'd4:    d = 9'd120;
			3'd5:    d = 9'd60;
			3'd6:    d = 9'd180;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: src/hssd_front.sv
// Front end: accepts input beats and classifies them as init, edge or reject.
// Uses hssd_pkg for the sector table and item types; feeds hssd_queue.
module hssd_front #(
	parameter int INTERVAL_BITS = hssd_pkg::INTERVAL_BITS_DEF
) (
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     opcode,
	input  logic [2:0]               hall_raw,
	input  logic [INTERVAL_BITS-1:0] edge_interval,
	input  logic                     q_full,
	output logic                     q_push,
	output hssd_pkg::item_cls_t      cls,
	output logic [INTERVAL_BITS-1:0] interval
);

	logic [hssd_pkg::SECTOR_BITS-1:0] sec;

	assign sec      = hssd_pkg::sector_of_raw(hall_raw);
	assign in_ready = !q_full;
	assign q_push   = in_valid && !q_full;
	assign interval = edge_interval;

	always_comb begin
		cls.sector = sec;
		if (opcode == hssd_pkg::OP_INIT) begin
			cls.kind = hssd_pkg::KIND_INIT;
		end else if (edge_interval != '0 && sec != hssd_pkg::SECTOR_NONE) begin
			cls.kind = hssd_pkg::KIND_EDGE;
		end else begin
			cls.kind = hssd_pkg::KIND_REJECT;
		end
	end

endmodule

// File: src/hssd_queue.sv
// Short register FIFO between the front end and the back end.
// Generic width and depth; no package dependency beyond defaults.
module hssd_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = hssd_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                do_push;
	logic                do_pop;

	assign full    = (count_q == CNT_BITS'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: src/hssd_div.sv
// Restoring serial divider: one quotient bit per cycle.
// Uses hssd_pkg for the numerator width.
module hssd_div #(
	parameter int INTERVAL_BITS = hssd_pkg::INTERVAL_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hssd_pkg::NUMER_BITS-1:0] numer,
	input  logic [INTERVAL_BITS-1:0]        denom,
	output logic                            busy,
	output logic [hssd_pkg::NUMER_BITS-1:0] quot
);

	localparam int NB       = hssd_pkg::NUMER_BITS;
	localparam int CNT_BITS = $clog2(NB + 1);

	logic                     busy_q;
	logic [CNT_BITS-1:0]      cnt_q;
	logic [INTERVAL_BITS-1:0] rem_q;
	logic [INTERVAL_BITS-1:0] den_q;
	logic [NB-1:0]            quo_q;
	logic [INTERVAL_BITS:0]   trial;
	logic [INTERVAL_BITS:0]   diff;
	logic                     ge;

	assign trial = {rem_q, quo_q[NB-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign diff  = trial - {1'b0, den_q};
	assign busy  = busy_q;
	assign quot  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NB);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// numerator shifts out of the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= numer;
			rem_q <= '0;
			den_q <= denom;
		end else if (busy_q) begin
			rem_q <= ge ? diff[INTERVAL_BITS-1:0] : trial[INTERVAL_BITS-1:0];
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

endmodule

// File: src/hssd_back.sv
// Back end: pops classified items, runs the divider, updates the decoder state.
// The state registers double as the output register. Uses hssd_pkg and hssd_div.
module hssd_back #(
	parameter int INTERVAL_BITS = hssd_pkg::INTERVAL_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    q_empty,
	input  hssd_pkg::item_cls_t                     q_cls,
	input  logic [INTERVAL_BITS-1:0]                q_interval,
	output logic                                    q_pop,
	input  logic [hssd_pkg::NUMER_BITS-1:0]         numer,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic                                    accepted,
	output logic [hssd_pkg::SECTOR_BITS-1:0]        sector,
	output logic signed [hssd_pkg::ROT_BITS-1:0]    rotation,
	output logic [hssd_pkg::NUMER_BITS-1:0]         speed,
	output logic [hssd_pkg::ANGLE_BITS-1:0]         angle_deg,
	output logic [hssd_pkg::TOTAL_BITS-1:0]         edge_total
);

	hssd_pkg::back_state_t state_q;
	hssd_pkg::back_state_t state_d;

	logic                                 out_valid_q;
	logic                                 accepted_q;
	logic [hssd_pkg::SECTOR_BITS-1:0]     sector_q;
	logic signed [hssd_pkg::ROT_BITS-1:0] dir_q;
	logic [hssd_pkg::NUMER_BITS-1:0]      speed_q;
	logic [hssd_pkg::ANGLE_BITS-1:0]      angle_q;
	logic [hssd_pkg::TOTAL_BITS-1:0]      total_q;
	logic [hssd_pkg::SECTOR_BITS-1:0]     pend_sector_q;

	logic                                 out_free;
	logic                                 div_start;
	logic                                 div_busy;
	logic [hssd_pkg::NUMER_BITS-1:0]      div_quot;
	logic                                 commit_edge;
	logic                                 commit_init;
	logic                                 commit_reject;
	logic signed [hssd_pkg::ROT_BITS-1:0] dir_d;

	assign out_free = !out_valid_q || out_ready;

	hssd_div #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (numer),
		.denom (q_interval),
		.busy  (div_busy),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hssd_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		q_pop         = 1'b0;
		div_start     = 1'b0;
		commit_edge   = 1'b0;
		commit_init   = 1'b0;
		commit_reject = 1'b0;
		unique case (state_q)
			hssd_pkg::BK_IDLE: begin
				if (!q_empty) begin
					if (q_cls.kind == hssd_pkg::KIND_EDGE) begin
						q_pop     = 1'b1;
						div_start = 1'b1;
						state_d   = hssd_pkg::BK_DIV;
					end else if (out_free) begin
						q_pop = 1'b1;
						if (q_cls.kind == hssd_pkg::KIND_INIT) begin
							commit_init = 1'b1;
						end else begin
							commit_reject = 1'b1;
						end
					end
				end
			end
			hssd_pkg::BK_DIV: begin
				if (!div_busy) begin
					state_d = hssd_pkg::BK_COMMIT;
				end
			end
			hssd_pkg::BK_COMMIT: begin
				if (out_free) begin
					commit_edge = 1'b1;
					state_d     = hssd_pkg::BK_IDLE;
				end
			end
			default: state_d = hssd_pkg::BK_IDLE;
		endcase
	end

	// direction only moves on a step to an adjacent sector
	always_comb begin
		dir_d = dir_q;
		if (sector_q != hssd_pkg::SECTOR_NONE && sector_q != pend_sector_q) begin
			if (hssd_pkg::fwd_after(sector_q) == pend_sector_q) begin
				dir_d = hssd_pkg::ROT_FWD;
			end else if (hssd_pkg::fwd_after(pend_sector_q) == sector_q) begin
				dir_d = hssd_pkg::ROT_REV;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			accepted_q    <= 1'b0;
			sector_q      <= hssd_pkg::SECTOR_NONE;
			dir_q         <= hssd_pkg::ROT_NONE;
			speed_q       <= '0;
			angle_q       <= '0;
			total_q       <= '0;
			pend_sector_q <= hssd_pkg::SECTOR_NONE;
		end else begin
			if (div_start) begin
				pend_sector_q <= q_cls.sector;
			end
			if (commit_edge || commit_init || commit_reject) begin
				out_valid_q <= 1'b1;
				accepted_q  <= !commit_reject;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (commit_init) begin
				sector_q <= q_cls.sector;
				dir_q    <= hssd_pkg::ROT_NONE;
				speed_q  <= '0;
				angle_q  <= '0;
				total_q  <= '0;
			end
			if (commit_edge) begin
				sector_q <= pend_sector_q;
				dir_q    <= dir_d;
				speed_q  <= div_quot;
				angle_q  <= hssd_pkg::deg_of_sector(pend_sector_q);
				total_q  <= total_q + 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign accepted   = accepted_q;
	assign sector     = sector_q;
	assign rotation   = dir_q;
	assign speed      = speed_q;
	assign angle_deg  = angle_q;
	assign edge_total = total_q;

endmodule

// File: src/hall_sensor_speed_direction_decoder.sv
// Top level of the three-phase Hall sensor decoder: APB register, front end,
// queue and back end. Uses hssd_pkg, hssd_front, hssd_queue, hssd_back.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per Hall edge or init
//   command: opcode, hall_raw, edge_interval. Output channel
//   (out_valid/out_ready) returns one beat per input beat, in order, showing
//   the decoder state after that item.
//   The APB port holds rpm_numerator at byte address 0; speed is
//   rpm_numerator / edge_interval, floored.
// Flow:
//   An init or rejected item passes through the queue and is registered into
//   the output state as the back end pops it. A valid edge runs the serial
//   divider, one quotient bit per cycle, and is committed when the divider is
//   done; the back end pops no new item before then. A two-entry queue keeps
//   taking input beats while the divider works; in_ready drops only when full.
// Reset: arst_n clears the state (sector, direction, speed, angle, count to
//   zero), empties the queue and reloads rpm_numerator with 5000000.
// Stall: while out_ready is low the result beat holds; the back end waits
//   and the queue then fills before the input side stalls.
module hall_sensor_speed_direction_decoder #(
	parameter int INTERVAL_BITS = hssd_pkg::INTERVAL_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [hssd_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [hssd_pkg::DATA_BITS-1:0]        pwdata,
	output logic [hssd_pkg::DATA_BITS-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  opcode,
	input  logic [2:0]                            hall_raw,
	input  logic [INTERVAL_BITS-1:0]              edge_interval,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  accepted,
	output logic [hssd_pkg::SECTOR_BITS-1:0]      sector,
	output logic signed [hssd_pkg::ROT_BITS-1:0]  rotation,
	output logic [hssd_pkg::NUMER_BITS-1:0]       speed,
	output logic [hssd_pkg::ANGLE_BITS-1:0]       angle_deg,
	output logic [hssd_pkg::TOTAL_BITS-1:0]       edge_total
);

	localparam int Q_WIDTH = $bits(hssd_pkg::item_cls_t) + INTERVAL_BITS;

	logic [hssd_pkg::NUMER_BITS-1:0] numer_q;
	logic                            sel_numer;

	hssd_pkg::item_cls_t      f_cls;
	logic [INTERVAL_BITS-1:0] f_interval;
	logic                     q_push;
	logic                     q_full;
	logic                     q_pop;
	logic                     q_empty;
	logic [Q_WIDTH-1:0]       q_dout;
	hssd_pkg::item_cls_t      q_cls;
	logic [INTERVAL_BITS-1:0] q_interval;

	assign pready    = 1'b1;
	assign sel_numer = (paddr[hssd_pkg::ADDR_BITS-1:2] == hssd_pkg::REG_RPM_NUMERATOR);
	assign prdata    = sel_numer ? hssd_pkg::DATA_BITS'(numer_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numer_q <= hssd_pkg::RPM_NUMER_RESET;
		end else if (psel && penable && pwrite && sel_numer) begin
			numer_q <= pwdata[hssd_pkg::NUMER_BITS-1:0];
		end
	end

	hssd_front #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_front (
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.hall_raw     (hall_raw),
		.edge_interval(edge_interval),
		.q_full       (q_full),
		.q_push       (q_push),
		.cls          (f_cls),
		.interval     (f_interval)
	);

	hssd_queue #(
		.WIDTH(Q_WIDTH),
		.DEPTH(hssd_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   ({f_cls, f_interval}),
		.full  (q_full),
		.pop   (q_pop),
		.dout  (q_dout),
		.empty (q_empty)
	);

	assign q_cls      = hssd_pkg::item_cls_t'(q_dout[Q_WIDTH-1:INTERVAL_BITS]);
	assign q_interval = q_dout[INTERVAL_BITS-1:0];

	hssd_back #(
		.INTERVAL_BITS(INTERVAL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_cls     (q_cls),
		.q_interval(q_interval),
		.q_pop     (q_pop),
		.numer     (numer_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.accepted  (accepted),
		.sector    (sector),
		.rotation  (rotation),
		.speed     (speed),
		.angle_deg (angle_deg),
		.edge_total(edge_total)
	);

endmodule

// File: src/hssd_checker.sv
// Port-level checks for the Hall sensor decoder, bound to the top level.
// Depends on hssd_pkg for field widths.
module hssd_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [hssd_pkg::SECTOR_BITS-1:0]     sector,
	input logic signed [hssd_pkg::ROT_BITS-1:0] rotation,
	input logic [hssd_pkg::NUMER_BITS-1:0]      speed,
	input logic [hssd_pkg::ANGLE_BITS-1:0]      angle_deg,
	input logic [hssd_pkg::TOTAL_BITS-1:0]      edge_total
);

	// a pending result beat holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(edge_total) && $stable(sector))
		else $error("result beat dropped or changed while stalled");

	// no sector means nothing has been decoded since reset or init
	a_no_sector_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sector == hssd_pkg::SECTOR_NONE |->
			speed == '0 && angle_deg == '0 && rotation == hssd_pkg::ROT_NONE
			&& edge_total == '0)
		else $error("state set while sector unknown");

	a_rot_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rotation == hssd_pkg::ROT_NONE || rotation == hssd_pkg::ROT_FWD
			|| rotation == hssd_pkg::ROT_REV)
		else $error("bad rotation code");

	a_angle_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle_deg == 9'd0 || angle_deg == 9'd60 || angle_deg == 9'd120
			|| angle_deg == 9'd180 || angle_deg == 9'd240 || angle_deg == 9'd300)
		else $error("angle not a sector angle");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sector != 3'd7)
		else $error("sector out of range");

endmodule

bind hall_sensor_speed_direction_decoder hssd_checker u_hssd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.sector       (sector),
	.rotation     (rotation),
	.speed        (speed),
	.angle_deg    (angle_deg),
	.edge_total   (edge_total)
);

// File: verif/hssd_result_check.sv
// Result checker for the Hall sensor decoder. It tracks the rpm register and the
// decoder state, predicts one report per input beat and compares output beats.
// Depends on hssd_pkg only.
module hssd_result_check #(
	parameter int INTERVAL_BITS = hssd_pkg::INTERVAL_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [hssd_pkg::ADDR_BITS-1:0]         paddr,
	input  logic [hssd_pkg::DATA_BITS-1:0]         pwdata,
	input  logic [hssd_pkg::DATA_BITS-1:0]         prdata,
	input  logic                                   pready,
	input  logic                                   in_valid,
	input  logic                                   in_ready,
	input  logic                                   opcode,
	input  logic [2:0]                             hall_raw,
	input  logic [INTERVAL_BITS-1:0]               edge_interval,
	input  logic                                   out_valid,
	input  logic                                   out_ready,
	input  logic                                   accepted,
	input  logic [hssd_pkg::SECTOR_BITS-1:0]       sector,
	input  logic signed [hssd_pkg::ROT_BITS-1:0]   rotation,
	input  logic [hssd_pkg::NUMER_BITS-1:0]        speed,
	input  logic [hssd_pkg::ANGLE_BITS-1:0]        angle_deg,
	input  logic [hssd_pkg::TOTAL_BITS-1:0]        edge_total,
	output int                                     fail_count,
	output int                                     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                             accepted;
		logic [hssd_pkg::SECTOR_BITS-1:0] sector;
		logic [hssd_pkg::ROT_BITS-1:0]    rotation;
		logic [hssd_pkg::NUMER_BITS-1:0]  rpm;
		logic [hssd_pkg::ANGLE_BITS-1:0]  deg;
		logic [hssd_pkg::TOTAL_BITS-1:0]  edges;
	} hall_report_t;

	logic [hssd_pkg::NUMER_BITS-1:0]  rpm_numer;
	logic [hssd_pkg::SECTOR_BITS-1:0] cur_sector;
	logic [hssd_pkg::ROT_BITS-1:0]    cur_rot;
	logic [hssd_pkg::NUMER_BITS-1:0]  cur_rpm;
	logic [hssd_pkg::ANGLE_BITS-1:0]  cur_deg;
	logic [hssd_pkg::TOTAL_BITS-1:0]  cur_edges;
	hall_report_t                     report_q[$];

	// pins H3 H2 H1 to sector, zero for the two impossible patterns
	function automatic logic [hssd_pkg::SECTOR_BITS-1:0] raw_to_sector(input logic [2:0] raw);
		case (raw)
			3'd2:    return 3'd1;
			3'd4:    return 3'd2;
			3'd6:    return 3'd3;
			3'd1:    return 3'd4;
			3'd3:    return 3'd5;
			3'd5:    return 3'd6;
			default: return hssd_pkg::SECTOR_NONE;
		endcase
	endfunction

	// successor in the forward order 1-5-4-6-2-3
	function automatic logic [hssd_pkg::SECTOR_BITS-1:0] next_forward(
			input logic [hssd_pkg::SECTOR_BITS-1:0] s);
		case (s)
			3'd1:    return 3'd5;
			3'd5:    return 3'd4;
			3'd4:    return 3'd6;
			3'd6:    return 3'd2;
			3'd2:    return 3'd3;
			3'd3:    return 3'd1;
			default: return hssd_pkg::SECTOR_NONE;
		endcase
	endfunction

	function automatic logic [hssd_pkg::ANGLE_BITS-1:0] sector_angle(
			input logic [hssd_pkg::SECTOR_BITS-1:0] s);
		case (s)
			3'd5:    return 9'd60;
			3'd4:    return 9'd120;
			3'd6:    return 9'd180;
			3'd2:    return 9'd240;
			3'd3:    return 9'd300;
			default: return 9'd0;
		endcase
	endfunction

	function automatic hall_report_t advance_decoder(input logic op, input logic [2:0] raw,
			input logic [INTERVAL_BITS-1:0] ticks);
		logic [hssd_pkg::SECTOR_BITS-1:0] fresh;
		logic [63:0]                      quot;
		hall_report_t                     r;
		fresh = raw_to_sector(raw);
		r.accepted = 1'b0;
		if (op == hssd_pkg::OP_INIT) begin
			cur_sector = fresh;
			cur_rot    = hssd_pkg::ROT_NONE;
			cur_rpm    = '0;
			cur_deg    = '0;
			cur_edges  = '0;
			r.accepted = 1'b1;
		end else if (ticks != '0 && fresh != hssd_pkg::SECTOR_NONE) begin
			cur_edges = cur_edges + 1'b1;
			// keep direction on unknown, repeated or non-adjacent sectors
			if (cur_sector != hssd_pkg::SECTOR_NONE && cur_sector != fresh) begin
				if (next_forward(cur_sector) == fresh)
					cur_rot = hssd_pkg::ROT_FWD;
				else if (next_forward(fresh) == cur_sector)
					cur_rot = hssd_pkg::ROT_REV;
			end
			quot       = 64'(rpm_numer) / 64'(ticks);
			cur_rpm    = quot[hssd_pkg::NUMER_BITS-1:0];
			cur_deg    = sector_angle(fresh);
			cur_sector = fresh;
			r.accepted = 1'b1;
		end
		r.sector   = cur_sector;
		r.rotation = cur_rot;
		r.rpm      = cur_rpm;
		r.deg      = cur_deg;
		r.edges    = cur_edges;
		return r;
	endfunction

	function automatic string show(input hall_report_t r);
		return $sformatf("acc=%0b sec=%0d rot=%0d rpm=%0d deg=%0d edges=%0d", r.accepted,
			r.sector, $signed(r.rotation), r.rpm, r.deg, r.edges);
	endfunction

	function automatic void log_fault(input string line);
		fail_count++;
		if (fail_count <= 10)
			$display("[%0t] %s", $realtime, line);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		hall_report_t want;
		hall_report_t got;
		if (!arst_n) begin
			rpm_numer  = hssd_pkg::RPM_NUMER_RESET;
			cur_sector = hssd_pkg::SECTOR_NONE;
			cur_rot    = hssd_pkg::ROT_NONE;
			cur_rpm    = '0;
			cur_deg    = '0;
			cur_edges  = '0;
			report_q.delete();
			fail_count = 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr[hssd_pkg::ADDR_BITS-1] == hssd_pkg::REG_RPM_NUMERATOR)
						rpm_numer = pwdata[hssd_pkg::NUMER_BITS-1:0];
				end else if (paddr[hssd_pkg::ADDR_BITS-1] == hssd_pkg::REG_RPM_NUMERATOR
						&& prdata !== hssd_pkg::DATA_BITS'(rpm_numer)) begin
					log_fault($sformatf("rpm_numerator read: exp %0d got %0d", rpm_numer,
						prdata));
				end
			end
			if (in_valid && in_ready)
				report_q.push_back(advance_decoder(opcode, hall_raw, edge_interval));
			if (out_valid && out_ready) begin
				got.accepted = accepted;
				got.sector   = sector;
				got.rotation = rotation;
				got.rpm      = speed;
				got.deg      = angle_deg;
				got.edges    = edge_total;
				if (report_q.size() == 0) begin
					log_fault({"result beat with none outstanding: ", show(got)});
				end else begin
					want = report_q.pop_front();
					if (got.accepted !== want.accepted || got.sector !== want.sector
							|| got.rotation !== want.rotation || got.rpm !== want.rpm
							|| got.deg !== want.deg || got.edges !== want.edges)
						log_fault({"result mismatch: exp ", show(want), " | got ", show(got)});
				end
			end
			pending <= report_q.size();
		end
	end

endmodule

// File: verif/tb_hall_sensor_speed_direction_decoder.sv
// Top of the Hall sensor decoder test: clock, reset, APB writes, edge beats and
// output back-pressure. Depends on hssd_pkg, the decoder RTL and hssd_result_check.
module tb_hall_sensor_speed_direction_decoder;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TICK_BITS = hssd_pkg::INTERVAL_BITS_DEF;
	localparam int LONG_HOLD = 400;
	localparam logic [hssd_pkg::ADDR_BITS-1:0] ADDR_NUMER =
		{hssd_pkg::REG_RPM_NUMERATOR, 2'b00};
	localparam logic [hssd_pkg::ADDR_BITS-1:0] ADDR_SPARE =
		{~hssd_pkg::REG_RPM_NUMERATOR, 2'b00};
	localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 psel;
	logic                                 penable;
	logic                                 pwrite;
	logic [hssd_pkg::ADDR_BITS-1:0]       paddr;
	logic [hssd_pkg::DATA_BITS-1:0]       pwdata;
	logic [hssd_pkg::DATA_BITS-1:0]       prdata;
	logic                                 pready;
	logic                                 in_valid;
	logic                                 in_ready;
	logic                                 opcode;
	logic [2:0]                           hall_raw;
	logic [TICK_BITS-1:0]                 edge_interval;
	logic                                 out_valid;
	logic                                 out_ready;
	logic                                 accepted;
	logic [hssd_pkg::SECTOR_BITS-1:0]     sector;
	logic signed [hssd_pkg::ROT_BITS-1:0] rotation;
	logic [hssd_pkg::NUMER_BITS-1:0]      speed;
	logic [hssd_pkg::ANGLE_BITS-1:0]      angle_deg;
	logic [hssd_pkg::TOTAL_BITS-1:0]      edge_total;
	int                                   fail_count;
	int                                   pending;

	bit gaps_on;
	bit long_hold_req;
	int burst_left;

	hall_sensor_speed_direction_decoder #(.INTERVAL_BITS(TICK_BITS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.hall_raw(hall_raw), .edge_interval(edge_interval),
		.out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
		.sector(sector), .rotation(rotation), .speed(speed),
		.angle_deg(angle_deg), .edge_total(edge_total)
	);

	hssd_result_check #(.INTERVAL_BITS(TICK_BITS)) u_check (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready), .opcode(opcode),
		.hall_raw(hall_raw), .edge_interval(edge_interval),
		.out_valid(out_valid), .out_ready(out_ready), .accepted(accepted),
		.sector(sector), .rotation(rotation), .speed(speed),
		.angle_deg(angle_deg), .edge_total(edge_total),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("Regression FAIL");
		$finish;
	end

	// raw pins of the forward sequence 1-5-4-6-2-3, by position
	function automatic logic [2:0] raw_at(input int pos);
		case (pos)
			0:       return 3'd2;
			1:       return 3'd3;
			2:       return 3'd1;
			3:       return 3'd5;
			4:       return 3'd4;
			default: return 3'd6;
		endcase
	endfunction

	task automatic apb_access(input logic wr, input logic [hssd_pkg::ADDR_BITS-1:0] addr,
			input logic [hssd_pkg::DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_numerator(input logic [hssd_pkg::NUMER_BITS-1:0] value);
		apb_access(1'b1, ADDR_NUMER, hssd_pkg::DATA_BITS'(value));
		apb_access(1'b0, ADDR_NUMER, '0);
	endtask

	task automatic offer_item(input logic op, input logic [2:0] raw,
			input logic [TICK_BITS-1:0] ticks);
		int gap;
		in_valid      <= 1'b1;
		opcode        <= op;
		hall_raw      <= raw;
		edge_interval <= ticks;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end else begin
				burst_left--;
			end
		end
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// receiver: stretches of always-ready, coin-flip, sparse and mostly-ready
	initial begin : receiver
		int mode;
		int span;
		out_ready <= 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 200);
			repeat (span) begin
				@(posedge clk);
				if (long_hold_req) begin
					long_hold_req = 1'b0;
					out_ready <= 1'b0;
					repeat (LONG_HOLD) @(posedge clk);
				end else begin
					case (mode)
						0:       out_ready <= 1'b1;
						1:       out_ready <= 1'($urandom_range(0, 1));
						2:       out_ready <= ($urandom_range(0, 3) == 0);
						default: out_ready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	initial begin : stimulus
		int                              pos;
		int                              step;
		int                              pick;
		logic                            op;
		logic [2:0]                      raw;
		logic [TICK_BITS-1:0]            ticks;
		logic [hssd_pkg::NUMER_BITS-1:0] numer;
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		in_valid      <= 1'b0;
		opcode        <= hssd_pkg::OP_EDGE;
		hall_raw      <= '0;
		edge_interval <= '0;
		gaps_on       = 1'b1;
		long_hold_req = 1'b0;
		burst_left    = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset value of the register, then hand-picked edge, reject and init beats
		apb_access(1'b0, ADDR_NUMER, '0);
		offer_item(hssd_pkg::OP_EDGE, 3'd2, 16'd1);
		offer_item(hssd_pkg::OP_EDGE, 3'd3, TICK_MAX);
		offer_item(hssd_pkg::OP_EDGE, 3'd1, 16'd1000);
		offer_item(hssd_pkg::OP_EDGE, 3'd1, 16'd500);
		offer_item(hssd_pkg::OP_EDGE, 3'd3, 16'd777);
		offer_item(hssd_pkg::OP_EDGE, 3'd0, 16'd100);
		offer_item(hssd_pkg::OP_EDGE, 3'd7, 16'd100);
		offer_item(hssd_pkg::OP_EDGE, 3'd2, 16'd0);
		offer_item(hssd_pkg::OP_EDGE, 3'd5, 16'd321);
		offer_item(hssd_pkg::OP_INIT, 3'd0, 16'd0);
		offer_item(hssd_pkg::OP_EDGE, 3'd4, 16'd42);
		offer_item(hssd_pkg::OP_INIT, 3'd7, TICK_MAX);
		offer_item(hssd_pkg::OP_INIT, 3'd6, 16'd1234);
		offer_item(hssd_pkg::OP_EDGE, 3'd2, 16'd3);
		offer_item(hssd_pkg::OP_EDGE, 3'd6, 16'd7);
		offer_item(hssd_pkg::OP_EDGE, 3'd4, 16'd19);
		offer_item(hssd_pkg::OP_EDGE, 3'd5, 16'd2500);
		offer_item(hssd_pkg::OP_EDGE, 3'd1, 16'h5555);
		offer_item(hssd_pkg::OP_EDGE, 3'd3, 16'hAAAA);
		offer_item(hssd_pkg::OP_EDGE, 3'd1, 16'd60000);
		offer_item(hssd_pkg::OP_INIT, 3'd1, TICK_MAX);
		wait_results();

		pos  = 2;
		step = 1;
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0:       numer = 24'd1;
				1:       numer = '1;
				2:       numer = hssd_pkg::NUMER_BITS'($urandom_range(1, 24'hFFFFFF));
				3:       numer = hssd_pkg::NUMER_BITS'($urandom_range(1, 4095));
				4:       numer = hssd_pkg::RPM_NUMER_RESET;
				default: numer = hssd_pkg::NUMER_BITS'($urandom_range(1, 24'hFFFFFF));
			endcase
			// unmapped address: write must not land in the register
			if (phase == 3)
				apb_access(1'b1, ADDR_SPARE,
					hssd_pkg::DATA_BITS'($urandom_range(1, 24'hFFFFFF)));
			set_numerator(numer);
			gaps_on = (phase != 2);
			for (int n = 0; n < 300; n++) begin
				if ((phase == 1 || phase == 4) && n == 100)
					long_hold_req = 1'b1;
				pick = $urandom_range(0, 9);
				if (pick == 0)
					ticks = TICK_BITS'($urandom_range(1, 15));
				else if (pick <= 5)
					ticks = TICK_BITS'($urandom_range(1, TICK_MAX));
				else if (pick == 6)
					ticks = TICK_MAX;
				else
					ticks = TICK_BITS'($urandom_range(100, 5000));
				op   = hssd_pkg::OP_EDGE;
				pick = $urandom_range(0, 99);
				if (pick < 83) begin
					// reverse now and then, otherwise keep turning
					if (pick >= 75)
						step = -step;
					pos = (pos + step + 6) % 6;
					raw = raw_at(pos);
				end else if (pick < 87) begin
					raw = raw_at(pos);
				end else if (pick < 91) begin
					pos = $urandom_range(0, 5);
					raw = raw_at(pos);
				end else if (pick < 94) begin
					raw = $urandom_range(0, 1) ? 3'd7 : 3'd0;
				end else if (pick < 97) begin
					raw   = 3'($urandom_range(0, 7));
					ticks = '0;
				end else begin
					op = hssd_pkg::OP_INIT;
					if ($urandom_range(0, 3) == 0) begin
						raw = $urandom_range(0, 1) ? 3'd7 : 3'd0;
					end else begin
						pos = $urandom_range(0, 5);
						raw = raw_at(pos);
					end
				end
				offer_item(op, raw, ticks);
			end
			wait_results();
		end

		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/hssd_pkg.sv
src/hssd_front.sv
src/hssd_queue.sv
src/hssd_div.sv
src/hssd_back.sv
src/hall_sensor_speed_direction_decoder.sv
src/hssd_checker.sv
verif/hssd_result_check.sv
verif/tb_hall_sensor_speed_direction_decoder.sv
